### hdl/mecanum_trapezoid_ramp_drive_macros.svh
// Assertion macros for the mecanum trapezoid ramp drive.
// No dependencies; included by the files that carry assertions.
`ifndef MECANUM_TRAPEZOID_RAMP_DRIVE_MACROS_SVH
`define MECANUM_TRAPEZOID_RAMP_DRIVE_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle
`define MTRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked in the cycle after the antecedent
`define MTRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/mtrd_pkg.sv
// Package for the mecanum trapezoid ramp drive: codes, constants, state type.
// No dependencies.
`timescale 1ns / 1ps
package mtrd_pkg;

    localparam int COUNT_BITS_DEF = 24;

    // Item function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    // Phase codes
    localparam logic [2:0] PHASE_STOPPED = 3'd0;
    localparam logic [2:0] PHASE_UP      = 3'd1;
    localparam logic [2:0] PHASE_CRUISE  = 3'd2;
    localparam logic [2:0] PHASE_DOWN    = 3'd3;
    localparam logic [2:0] PHASE_LOADED  = 3'd4;

    // Register indexes
    localparam logic [1:0] CFG_MAX_RPM     = 2'd0;
    localparam logic [1:0] CFG_OFFSET_UP   = 2'd1;
    localparam logic [1:0] CFG_OFFSET_DOWN = 2'd2;

    localparam logic [9:0] MAX_RPM_RST = 10'd200;

    // 249 * 23167: full duty times 0.707 in Q1.15
    localparam logic signed [23:0] COUPLE_GAIN = 24'sd5768583;
    localparam int COUPLE_SHIFT = 15;
    localparam logic [7:0] DUTY_MAX = 8'd255;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL1  = 7'b0000010,
        ST_MUL2  = 7'b0000100,
        ST_SUM   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_STORE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

### hdl/mecanum_trapezoid_ramp_drive.sv
// Mecanum inverse kinematics with trapezoidal duty ramp, bit-serial divider.
// Depends on mtrd_pkg and mecanum_trapezoid_ramp_drive_macros.svh.
//
// channel | direction | beat contents
// s_      | in        | func, velocities, distance, direction, encoder count
// m_      | out       | four wheel duties and phase
// cfg_    | in        | register index and data, always ready
//
// A load beat runs multiply, sum, divide and store for each wheel, a ramp sample two multiplies,
// sum, divide and store; the restoring divider retires one quotient bit per cycle for each wheel.
// Cruise and end-of-move samples, cancel and unused codes go straight to the done state.
// One beat is in work at a time; a new beat is taken while a result waits at m_.
// Reset is synchronous and active low and clears all move state.
`timescale 1ns / 1ps
`include "mecanum_trapezoid_ramp_drive_macros.svh"
module mecanum_trapezoid_ramp_drive #(
    parameter int COUNT_BITS = mtrd_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [9:0]                   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic signed [9:0]            s_vel_x,
    input  logic signed [9:0]            s_vel_y,
    input  logic signed [9:0]            s_vel_rot,
    input  logic [COUNT_BITS-1:0]        s_distance_counts,
    input  logic signed [1:0]            s_direction,
    input  logic signed [COUNT_BITS-1:0] s_encoder_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [8:0]            m_duty_wheel0,
    output logic signed [8:0]            m_duty_wheel1,
    output logic signed [8:0]            m_duty_wheel2,
    output logic signed [8:0]            m_duty_wheel3,
    output logic [2:0]                   m_phase
);

    localparam int MA = 24;
    localparam int BW = COUNT_BITS + 1;
    localparam int PW = MA + BW;
    localparam int NW = COUNT_BITS + 14;
    localparam int CW = $clog2(NW + 1);

    mtrd_pkg::state_t state_reg, state_next;

    logic [9:0]                   max_rpm_reg;
    logic [7:0]                   offset_up_reg, offset_down_reg;
    logic signed [9:0]            cruise_reg [4];
    logic [COUNT_BITS-1:0]        move_length_reg;
    logic signed [1:0]            travel_sign_reg;
    logic signed [9:0]            vel_x_reg, vel_y_reg, vel_rot_reg;
    logic signed [COUNT_BITS-1:0] enc_reg;
    logic                         load_reg, up_reg;
    logic [1:0]                   wheel_reg;
    logic signed [PW-1:0]         p1_reg, p2_reg;
    logic [NW-1:0]                quo_reg;
    logic [COUNT_BITS-1:0]        rem_reg, div_reg;
    logic                         neg_reg;
    logic [CW-1:0]                cnt_reg;
    logic signed [8:0]            duty_reg [4];
    logic [2:0]                   phase_reg;

    // Classify a sample against the stored move
    logic [COUNT_BITS-1:0] abs_enc, eighth, seven_eighth;
    logic                  at_end, in_cruise, in_up;
    assign abs_enc      = s_encoder_count[COUNT_BITS-1] ? COUNT_BITS'(-s_encoder_count)
                                                        : s_encoder_count;
    assign eighth       = move_length_reg >> 3;
    assign seven_eighth = (eighth << 3) - eighth;
    assign at_end       = abs_enc >= move_length_reg;
    assign in_cruise    = (abs_enc >= eighth) && (abs_enc <= seven_eighth);
    assign in_up        = abs_enc <= eighth;

    // Wheel sum of the coupling matrix
    logic signed [11:0] vx, vy, vr, wheel_sum;
    assign vx = 12'(vel_x_reg);
    assign vy = 12'(vel_y_reg);
    assign vr = 12'(vel_rot_reg);
    always_comb begin
        case (wheel_reg)
            2'd0:    wheel_sum = -vx + vy - vr;
            2'd1:    wheel_sum = vx + vy + vr;
            2'd2:    wheel_sum = -vx + vy + vr;
            default: wheel_sum = vx + vy - vr;
        endcase
    end

    // Signed offset terms for the current wheel
    logic               v_pos, v_neg;
    logic signed [9:0]  off_s, v_off, cur_c;
    logic signed [10:0] diff_c;
    logic signed [13:0] k_down;
    assign v_pos  = travel_sign_reg == 2'sb01;
    assign v_neg  = travel_sign_reg[1];
    assign off_s  = up_reg ? 10'(offset_up_reg) : 10'(offset_down_reg);
    assign v_off  = v_pos ? off_s : (v_neg ? -off_s : 10'sd0);
    assign cur_c  = cruise_reg[wheel_reg];
    assign diff_c = 11'(cur_c) - 11'(v_off);
    assign k_down = (14'(cur_c) <<< 3) - ((14'(v_off) <<< 3) - 14'(v_off));

    // Shared multiplier
    logic signed [MA-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    always_comb begin
        if (state_reg == mtrd_pkg::ST_MUL1) begin
            mul_a = load_reg ? mtrd_pkg::COUPLE_GAIN : MA'(diff_c);
            mul_b = load_reg ? BW'(wheel_sum) : BW'(enc_reg);
        end else begin
            mul_a = up_reg ? MA'({1'b0, offset_up_reg}) : MA'(k_down);
            mul_b = BW'({1'b0, move_length_reg});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Numerator and divider operands
    logic signed [PW-1:0] t_up, num_w;
    logic [PW-1:0]        mag_w, mag_sh;
    logic [9:0]           rpm_eff;
    assign t_up = (p1_reg <<< 3) + p2_reg;
    always_comb begin
        if (load_reg)     num_w = p1_reg;
        else if (up_reg)  num_w = v_pos ? t_up : (v_neg ? -t_up : '0);
        else              num_w = p2_reg - (v_pos ? (p1_reg <<< 3)
                                          : (v_neg ? -(p1_reg <<< 3) : '0));
    end
    assign mag_w   = num_w[PW-1] ? PW'(-num_w) : PW'(num_w);
    assign mag_sh  = load_reg ? (mag_w >> mtrd_pkg::COUPLE_SHIFT) : mag_w;
    assign rpm_eff = (max_rpm_reg == '0) ? 10'd1 : max_rpm_reg;

    // One restoring step per cycle
    logic [COUNT_BITS:0] trial, trial_sub;
    logic                fits;
    assign trial     = {rem_reg, quo_reg[NW-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = trial >= {1'b0, div_reg};

    // Saturate the quotient and restore its sign
    logic [7:0]        sat_mag;
    logic signed [8:0] sat_duty;
    assign sat_mag  = (quo_reg > NW'(mtrd_pkg::DUTY_MAX)) ? mtrd_pkg::DUTY_MAX : quo_reg[7:0];
    assign sat_duty = neg_reg ? -9'(sat_mag) : 9'(sat_mag);

    logic out_free;
    assign out_free  = !m_valid || m_ready;
    assign s_ready   = state_reg == mtrd_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;

    // Sequence the per-wheel work
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mtrd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == mtrd_pkg::FUNC_LOAD)
                        state_next = mtrd_pkg::ST_MUL1;
                    else if (s_func == mtrd_pkg::FUNC_SAMPLE && !at_end && !in_cruise)
                        state_next = mtrd_pkg::ST_MUL1;
                    else
                        state_next = mtrd_pkg::ST_DONE;
                end
            end
            mtrd_pkg::ST_MUL1:  state_next = load_reg ? mtrd_pkg::ST_SUM : mtrd_pkg::ST_MUL2;
            mtrd_pkg::ST_MUL2:  state_next = mtrd_pkg::ST_SUM;
            mtrd_pkg::ST_SUM:   state_next = mtrd_pkg::ST_DIV;
            mtrd_pkg::ST_DIV:   if (cnt_reg == CW'(1)) state_next = mtrd_pkg::ST_STORE;
            mtrd_pkg::ST_STORE: state_next = (wheel_reg == 2'd3) ? mtrd_pkg::ST_DONE
                                                                 : mtrd_pkg::ST_MUL1;
            mtrd_pkg::ST_DONE:  if (out_free) state_next = mtrd_pkg::ST_IDLE;
            default:            state_next = mtrd_pkg::ST_IDLE;
        endcase
    end

    // Control and move state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mtrd_pkg::ST_IDLE;
            max_rpm_reg     <= mtrd_pkg::MAX_RPM_RST;
            offset_up_reg   <= '0;
            offset_down_reg <= '0;
            move_length_reg <= '0;
            travel_sign_reg <= '0;
            cnt_reg         <= '0;
            m_valid         <= 1'b0;
            for (int k = 0; k < 4; k++) cruise_reg[k] <= '0;
        end else begin
            state_reg <= state_next;

            // Take configuration beats
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mtrd_pkg::CFG_MAX_RPM:     max_rpm_reg     <= cfg_data;
                    mtrd_pkg::CFG_OFFSET_UP:   offset_up_reg   <= cfg_data[7:0];
                    mtrd_pkg::CFG_OFFSET_DOWN: offset_down_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // Update move state on an accepted beat
            if (s_valid && s_ready) begin
                if (s_func == mtrd_pkg::FUNC_LOAD) begin
                    move_length_reg <= s_distance_counts;
                    travel_sign_reg <= (s_direction == 2'sb10) ? 2'sb11 : s_direction;
                end else if (s_func == mtrd_pkg::FUNC_CANCEL) begin
                    move_length_reg <= '0;
                    travel_sign_reg <= '0;
                    for (int k = 0; k < 4; k++) cruise_reg[k] <= '0;
                end else if (s_func == mtrd_pkg::FUNC_SAMPLE && at_end) begin
                    move_length_reg <= '0;
                end
            end

            if (state_reg == mtrd_pkg::ST_SUM)
                cnt_reg <= CW'(NW);
            else if (state_reg == mtrd_pkg::ST_DIV)
                cnt_reg <= cnt_reg - CW'(1);

            if (state_reg == mtrd_pkg::ST_STORE && load_reg)
                cruise_reg[wheel_reg] <= 10'(sat_duty);

            // Hold the result until the beat is taken
            if (state_reg == mtrd_pkg::ST_DONE && out_free)
                m_valid <= 1'b1;
            else if (m_ready)
                m_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            vel_x_reg   <= s_vel_x;
            vel_y_reg   <= s_vel_y;
            vel_rot_reg <= s_vel_rot;
            enc_reg     <= s_encoder_count;
            load_reg    <= s_func == mtrd_pkg::FUNC_LOAD;
            up_reg      <= in_up;
            wheel_reg   <= '0;
            for (int k = 0; k < 4; k++)
                duty_reg[k] <= (s_func == mtrd_pkg::FUNC_SAMPLE && !at_end && in_cruise)
                               ? 9'(cruise_reg[k]) : '0;
            if (s_func == mtrd_pkg::FUNC_LOAD)
                phase_reg <= mtrd_pkg::PHASE_LOADED;
            else if (s_func != mtrd_pkg::FUNC_SAMPLE || at_end)
                phase_reg <= mtrd_pkg::PHASE_STOPPED;
            else if (in_cruise)
                phase_reg <= mtrd_pkg::PHASE_CRUISE;
            else if (in_up)
                phase_reg <= mtrd_pkg::PHASE_UP;
            else
                phase_reg <= mtrd_pkg::PHASE_DOWN;
        end
        if (state_reg == mtrd_pkg::ST_MUL1) p1_reg <= mul_p;
        if (state_reg == mtrd_pkg::ST_MUL2) p2_reg <= mul_p;
        if (state_reg == mtrd_pkg::ST_SUM) begin
            neg_reg <= num_w[PW-1];
            quo_reg <= mag_sh[NW-1:0];
            rem_reg <= '0;
            div_reg <= load_reg ? COUNT_BITS'(rpm_eff) : move_length_reg;
        end
        // Shift in one quotient bit
        if (state_reg == mtrd_pkg::ST_DIV) begin
            rem_reg <= fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
        if (state_reg == mtrd_pkg::ST_STORE) begin
            if (!load_reg) duty_reg[wheel_reg] <= sat_duty;
            wheel_reg <= wheel_reg + 2'd1;
        end
        if (state_reg == mtrd_pkg::ST_DONE && out_free) begin
            m_duty_wheel0 <= duty_reg[0];
            m_duty_wheel1 <= duty_reg[1];
            m_duty_wheel2 <= duty_reg[2];
            m_duty_wheel3 <= duty_reg[3];
            m_phase       <= phase_reg;
        end
    end

    `MTRD_ASSERT(a_phase_range, aclk, aresetn, m_valid |-> (m_phase <= mtrd_pkg::PHASE_LOADED), "phase code out of range")
    `MTRD_ASSERT(a_quiet_zero, aclk, aresetn, (m_valid && (m_phase == mtrd_pkg::PHASE_STOPPED || m_phase == mtrd_pkg::PHASE_LOADED)) |-> (m_duty_wheel0 == 9'sd0 && m_duty_wheel1 == 9'sd0 && m_duty_wheel2 == 9'sd0 && m_duty_wheel3 == 9'sd0), "duty not zero while stopped or loaded")
    `MTRD_ASSERT(a_cnt_div, aclk, aresetn, (cnt_reg != '0) |-> (state_reg == mtrd_pkg::ST_DIV), "divider count live outside divide")
    `MTRD_ASSERT_NEXT(a_one_beat, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken while busy")

endmodule

### bench/tb_mecanum_trapezoid_ramp_drive.sv
// Self-checking bench for the mecanum trapezoid ramp drive: predicts each result beat
// from its own model of kinematics and ramp, and compares it with the m_ channel.
// Depends on mtrd_pkg and the mecanum_trapezoid_ramp_drive RTL.
`timescale 1ns / 1ps
module tb_mecanum_trapezoid_ramp_drive;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_TARGET = 1800;

    typedef struct {
        bit               is_cfg;
        logic [1:0]       cfg_idx;
        logic [9:0]       cfg_val;
        logic [1:0]       func;
        logic signed [9:0] vx, vy, vr;
        logic [23:0]      dist_cnt;
        logic signed [1:0] dir;
        logic signed [23:0] enc;
        bit               drain;
        int               mode;
    } cmd_t;

    typedef struct {
        logic signed [8:0] d [4];
        logic [2:0]        phase;
    } duty_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic s_valid = 1'b0, s_ready;
    logic [1:0] s_func = '0;
    logic signed [9:0] s_vel_x = '0, s_vel_y = '0, s_vel_rot = '0;
    logic [23:0] s_distance_counts = '0;
    logic signed [1:0] s_direction = '0;
    logic signed [23:0] s_encoder_count = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [8:0] m_duty_wheel0, m_duty_wheel1, m_duty_wheel2, m_duty_wheel3;
    logic [2:0] m_phase;

    // Predictor state and register copies
    logic [9:0]        rpm_reg = mtrd_pkg::MAX_RPM_RST;
    logic [7:0]        up_off = '0, down_off = '0;
    logic signed [9:0] cruise [4] = '{default: '0};
    logic [23:0]       move_len = '0;
    logic signed [1:0] trav_sign = '0;

    cmd_t  cmd_q [$];
    duty_t duty_q [$];
    int    errors = 0;
    int    cur_mode = 0;
    int    n_items = 0;
    int    idle_cnt = 0;

    mecanum_trapezoid_ramp_drive u_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint clamp_duty(input longint v);
        if (v > 255) return 255;
        if (v < -255) return -255;
        return v;
    endfunction

    // Work out the duties and phase caused by one beat, and advance the move state
    function automatic duty_t predict_duties(input cmd_t c);
        duty_t  r;
        longint x, y, w, rpm, e, a, len, eighth, v, ou, od, cd, num;
        longint s [4];
        for (int k = 0; k < 4; k++) r.d[k] = '0;
        r.phase = mtrd_pkg::PHASE_STOPPED;
        case (c.func)
            mtrd_pkg::FUNC_LOAD: begin
                x = c.vx; y = c.vy; w = c.vr;
                rpm = (rpm_reg == 0) ? 1 : longint'(rpm_reg);
                s[0] = -x + y - w; s[1] = x + y + w;
                s[2] = -x + y + w; s[3] = x + y - w;
                for (int k = 0; k < 4; k++)
                    cruise[k] = 10'(clamp_duty((249 * s[k] * 23167) / (32768 * rpm)));
                move_len = c.dist_cnt;
                trav_sign = (c.dir == -2) ? -2'sd1 : c.dir;
                r.phase = mtrd_pkg::PHASE_LOADED;
            end
            mtrd_pkg::FUNC_CANCEL: begin
                for (int k = 0; k < 4; k++) cruise[k] = '0;
                move_len = '0;
                trav_sign = '0;
            end
            mtrd_pkg::FUNC_SAMPLE: begin
                e = c.enc;
                a = (e < 0) ? -e : e;
                len = longint'(move_len);
                eighth = len >>> 3;
                v = trav_sign;
                ou = up_off; od = down_off;
                if (a >= len) begin
                    move_len = '0;
                end else if (a >= eighth && a <= 7 * eighth) begin
                    for (int k = 0; k < 4; k++) r.d[k] = 9'(cruise[k]);
                    r.phase = mtrd_pkg::PHASE_CRUISE;
                end else if (a <= eighth) begin
                    for (int k = 0; k < 4; k++) begin
                        cd = cruise[k];
                        num = v * (8 * (cd - v * ou) * e + ou * len);
                        r.d[k] = 9'(clamp_duty(num / len));
                    end
                    r.phase = mtrd_pkg::PHASE_UP;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        cd = cruise[k];
                        num = -(8 * (cd - v * od) * v * e) + (8 * cd - 7 * v * od) * len;
                        r.d[k] = 9'(clamp_duty(num / len));
                    end
                    r.phase = mtrd_pkg::PHASE_DOWN;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_cfg(input logic [1:0] idx, input int val, input int mode);
        cmd_t c;
        c = '{default: 0};
        c.is_cfg = 1; c.cfg_idx = idx; c.cfg_val = val[9:0]; c.mode = mode;
        cmd_q.push_back(c);
    endtask

    task automatic add_item(input logic [1:0] func, input int vx, input int vy, input int vr,
                            input int dist_len, input int dir, input int enc,
                            input bit drain, input int mode);
        cmd_t c;
        c = '{default: 0};
        c.func = func; c.vx = vx[9:0]; c.vy = vy[9:0]; c.vr = vr[9:0];
        c.dist_cnt = dist_len[23:0]; c.dir = dir[1:0]; c.enc = enc[23:0];
        c.drain = drain; c.mode = mode;
        cmd_q.push_back(c);
        n_items++;
    endtask

    // One move: load with random content, then samples at random points of the distance
    task automatic add_move(input int mode);
        int len, n, dir, enc, pick, e8;
        pick = $urandom_range(0, 9);
        if (pick < 2) len = $urandom_range(0, 15);
        else if (pick < 9) len = $urandom_range(16, 4000);
        else len = $urandom & 24'hFFFFFF;
        dir = $urandom_range(0, 3);
        add_item(mtrd_pkg::FUNC_LOAD, $urandom, $urandom, $urandom, len, dir, $urandom, 0,
                 mode);
        n = $urandom_range(2, 8);
        e8 = len >> 3;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: enc = e8;
                1: enc = 7 * e8;
                2: enc = len;
                3: enc = 0;
                default: enc = $urandom_range(0, len + e8 + 1);
            endcase
            if ($urandom_range(0, 1)) enc = -enc;
            add_item(mtrd_pkg::FUNC_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     enc, 0, mode);
        end
    endtask

    // Fill the stimulus: directed beats, then four phases of random moves and beats
    initial begin
        int cfg_rpm [4];
        int cfg_up [4];
        int cfg_dn [4];
        int pick;
        cfg_rpm = '{1, 1023, 200, 37};
        cfg_up = '{0, 249, 100, 17};
        cfg_dn = '{249, 0, 60, 128};

        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_LOAD, 511, 511, 511, 800, 1, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 50, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, -400, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 750, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 800, 0, 0);
        add_item(mtrd_pkg::FUNC_LOAD, -511, -511, -511, 16777215, -2, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, -8388608, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 8388607, 0, 0);
        add_item(mtrd_pkg::FUNC_LOAD, -512, 300, -7, 5, -1, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 4, 0, 0);
        add_item(mtrd_pkg::FUNC_LOAD, 100, -200, 50, 64, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 3, 0, 0);
        add_item(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 60, 0, 0);
        add_item(mtrd_pkg::FUNC_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 1, 1, 0);

        for (int m = 0; m < 4; m++) begin
            add_cfg(mtrd_pkg::CFG_MAX_RPM, cfg_rpm[m], m);
            add_cfg(mtrd_pkg::CFG_OFFSET_UP, cfg_up[m], m);
            add_cfg(mtrd_pkg::CFG_OFFSET_DOWN, cfg_dn[m], m);
            while (n_items < 19 + (m + 1) * (ITEM_TARGET - 19) / 4) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) add_move(m);
                else if (pick == 16)
                    add_item(mtrd_pkg::FUNC_CANCEL, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, 0, m);
                else if (pick == 17)
                    add_item(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, 0, m);
                else if (pick == 18)
                    add_item(mtrd_pkg::FUNC_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, 0, m);
                else
                    add_item(mtrd_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, $urandom_range(0, 100), 1,
                             m);
            end
        end
    end

    // Hold reset, then release it
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: predict on accepted beats, issue the next beat or register write
    always @(posedge aclk) begin
        bit   s_acc, c_acc, idle;
        cmd_t c;
        s_acc = s_valid && s_ready;
        c_acc = cfg_valid && cfg_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                c.func = s_func; c.vx = s_vel_x; c.vy = s_vel_y; c.vr = s_vel_rot;
                c.dist_cnt = s_distance_counts; c.dir = s_direction; c.enc = s_encoder_count;
                duty_q.push_back(predict_duties(c));
            end
            if (c_acc) begin
                case (cfg_index)
                    mtrd_pkg::CFG_MAX_RPM:     rpm_reg = cfg_data;
                    mtrd_pkg::CFG_OFFSET_UP:   up_off = cfg_data[7:0];
                    mtrd_pkg::CFG_OFFSET_DOWN: down_off = cfg_data[7:0];
                    default: ;
                endcase
            end
            if ((s_valid && !s_acc) || (cfg_valid && !c_acc) || cmd_q.size() == 0) begin
                if (s_acc) s_valid <= 1'b0;
                if (c_acc) cfg_valid <= 1'b0;
            end else begin
                c = cmd_q[0];
                cur_mode = c.mode;
                idle = (c.mode == 1) ? ($urandom_range(0, 99) < 60) :
                       (c.mode == 3) ? ($urandom_range(0, 99) < 24) : 1'b0;
                // Registers change and drained beats start only once the block is idle
                if ((c.is_cfg || c.drain) && (s_acc || duty_q.size() != 0 || m_valid))
                    idle = 1'b1;
                if (idle) begin
                    if (s_acc) s_valid <= 1'b0;
                    if (c_acc) cfg_valid <= 1'b0;
                end else if (c.is_cfg) begin
                    void'(cmd_q.pop_front());
                    if (s_acc) s_valid <= 1'b0;
                    cfg_valid <= 1'b1;
                    cfg_index <= c.cfg_idx;
                    cfg_data <= c.cfg_val;
                end else begin
                    void'(cmd_q.pop_front());
                    if (c_acc) cfg_valid <= 1'b0;
                    s_valid <= 1'b1;
                    s_func <= c.func;
                    s_vel_x <= c.vx; s_vel_y <= c.vy; s_vel_rot <= c.vr;
                    s_distance_counts <= c.dist_cnt;
                    s_direction <= c.dir;
                    s_encoder_count <= c.enc;
                end
            end
        end
    end

    // Monitor: stall at random and check each result beat against the oldest prediction
    always @(posedge aclk) begin
        duty_t exp_d;
        logic signed [8:0] act [4];
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                act = '{m_duty_wheel0, m_duty_wheel1, m_duty_wheel2, m_duty_wheel3};
                if (duty_q.size() == 0) begin
                    $display("%0t: unexpected result beat, phase %0d", $time, m_phase);
                    errors++;
                end else begin
                    exp_d = duty_q.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (act[k] !== exp_d.d[k]) begin
                            $display("%0t: wheel %0d duty expected %0d actual %0d",
                                     $time, k, exp_d.d[k], act[k]);
                            errors++;
                        end
                    if (m_phase !== exp_d.phase) begin
                        $display("%0t: phase expected %0d actual %0d",
                                 $time, exp_d.phase, m_phase);
                        errors++;
                    end
                end
            end
            m_ready <= (cur_mode == 2) ? ($urandom_range(0, 99) >= 60) :
                       (cur_mode == 3) ? ($urandom_range(0, 99) >= 24) : 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Wait for the stimulus to drain, then give the verdict
    initial begin
        @(posedge aresetn);
        do @(posedge aclk);
        while (cmd_q.size() != 0 || s_valid || cfg_valid || duty_q.size() != 0);
        repeat (300) @(posedge aclk);
        if (duty_q.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, duty_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### mecanum_trapezoid_ramp_drive.f
+incdir+hdl
hdl/mtrd_pkg.sv
hdl/mecanum_trapezoid_ramp_drive.sv
bench/tb_mecanum_trapezoid_ramp_drive.sv
